>>> rtl/hlbrc_pkg.sv
// ----------------------------------------------------------------------------
// hlbrc_pkg
// Shared types and constants for the hop-limited reach counter.
// ----------------------------------------------------------------------------
package hlbrc_pkg;

    localparam logic CMD_ADD_EDGE = 1'b0;
    localparam logic CMD_QUERY    = 1'b1;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    localparam int          HOP_LIMIT_W     = 4;
    localparam logic [3:0]  HOP_LIMIT_RESET = 4'd6;

    // node numbering is tied to the 10-bit node fields of the input beat
    localparam int   MAX_NODES = 1024;
    localparam int   NODE_W    = 10;

    localparam int   PADDR_W      = 1;
    localparam logic [0:0] REG_HOP_LIMIT = 1'b0;

    typedef struct packed {
        logic [0:0]  cmd;
        logic [9:0]  node_a;
        logic [9:0]  node_b;
    } in_beat_t;

    typedef struct packed {
        logic [0:0]  status;
        logic [10:0] reached_count;
    } out_beat_t;

endpackage

>>> rtl/hlbrc_if.sv
// ----------------------------------------------------------------------------
// hlbrc_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface hlbrc_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/hlbrc_ctrl.sv
// ----------------------------------------------------------------------------
// hlbrc_ctrl
// Sequencer and memories: adjacency lists, seen map and walk queue.
// ----------------------------------------------------------------------------
module hlbrc_ctrl #(
    parameter int MAX_SLOTS = 8192
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [hlbrc_pkg::HOP_LIMIT_W-1:0] hop_limit,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hlbrc_pkg::in_beat_t           in_beat,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hlbrc_pkg::out_beat_t          out_beat
);
    localparam int MAX_NODES = hlbrc_pkg::MAX_NODES;
    localparam int NW = hlbrc_pkg::NODE_W;
    localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PW = $clog2(MAX_SLOTS + 1);
    localparam int QW = $clog2(MAX_NODES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ADD1  = 4'd1;
    localparam logic [3:0] ST_ADD2  = 4'd2;
    localparam logic [3:0] ST_CLR   = 4'd3;
    localparam logic [3:0] ST_DEQ   = 4'd4;
    localparam logic [3:0] ST_HEAD  = 4'd5;
    localparam logic [3:0] ST_SLOT  = 4'd6;
    localparam logic [3:0] ST_SEEN  = 4'd7;
    localparam logic [3:0] ST_OUT   = 4'd8;
    localparam logic [3:0] ST_QRD   = 4'd9;
    localparam logic [3:0] ST_HRD   = 4'd10;
    localparam logic [3:0] ST_NB    = 4'd11;

    // memories
    logic [PW-1:0] head_mem [MAX_NODES];
    logic [PW-1:0] next_mem [MAX_SLOTS];
    logic [NW-1:0] nb_mem   [MAX_SLOTS];
    logic          seen_mem [MAX_NODES];
    logic [NW-1:0] q_mem    [MAX_NODES];

    logic [3:0]    state_reg;
    logic [PW-1:0] used_reg;
    logic [NW-1:0] a_reg, b_reg;
    logic [QW-1:0] qh_reg, qt_reg, lend_reg;
    logic [3:0]    depth_reg;
    logic [10:0]   count_reg;
    logic [PW-1:0] p_reg;
    logic [NW:0]   clr_reg;
    logic          hinit_reg;
    logic [NW:0]   hclr_reg;
    logic          ov_reg;
    hlbrc_pkg::out_beat_t ob_reg;

    // registered read data
    logic [PW-1:0] head_rd;
    logic [PW-1:0] next_rd;
    logic [NW-1:0] nb_rd;
    logic          seen_rd;
    logic [NW-1:0] q_rd;

    assign in_ready  = (state_reg == ST_IDLE) && !ov_reg && hinit_reg;
    assign out_valid = ov_reg;
    assign out_beat  = ob_reg;

    // read addresses (registered reads below)
    logic [NW-1:0] head_ra;
    logic [SW-1:0] slot_ra;
    logic [NW-1:0] seen_ra;
    logic [NW-1:0] q_ra;
    always_comb
    begin
        head_ra = a_reg;
        if (state_reg == ST_HRD)
            head_ra = q_rd;
        else if (state_reg == ST_IDLE)
            head_ra = in_beat.node_a;
        else if (state_reg == ST_ADD1)
            head_ra = b_reg;
        slot_ra = SW'(p_reg - PW'(1));
        seen_ra = nb_rd;
        q_ra    = qh_reg[NW-1:0];
    end

    always_ff @(posedge clk)
    begin
        head_rd <= head_mem[head_ra];
        next_rd <= next_mem[slot_ra];
        nb_rd   <= nb_mem[slot_ra];
        seen_rd <= seen_mem[seen_ra];
        q_rd    <= q_mem[q_ra];
    end

    logic full_w;
    assign full_w = (used_reg > PW'(MAX_SLOTS - 2));

    // memory writes
    always_ff @(posedge clk)
    begin
        if (!hinit_reg)
            head_mem[hclr_reg[NW-1:0]] <= '0;
        else if (state_reg == ST_ADD1)
            head_mem[a_reg] <= used_reg + PW'(1);
        else if (state_reg == ST_ADD2)
            head_mem[b_reg] <= used_reg + PW'(1);
        if (state_reg == ST_ADD1)
        begin
            nb_mem[used_reg[SW-1:0]]   <= b_reg;
            next_mem[used_reg[SW-1:0]] <= head_rd;
        end
        else if (state_reg == ST_ADD2)
        begin
            // a self loop links to the slot written just before
            nb_mem[used_reg[SW-1:0]]   <= a_reg;
            next_mem[used_reg[SW-1:0]] <= (a_reg == b_reg) ? used_reg : head_rd;
        end
        if (state_reg == ST_CLR)
            seen_mem[clr_reg[NW-1:0]] <= (clr_reg[NW-1:0] == a_reg);
        else if (state_reg == ST_SEEN && !seen_rd && qt_reg < QW'(MAX_NODES))
            seen_mem[nb_rd] <= 1'b1;
        if (state_reg == ST_CLR && clr_reg == '0)
            q_mem[0] <= a_reg;
        else if (state_reg == ST_SEEN && !seen_rd && qt_reg < QW'(MAX_NODES))
            q_mem[qt_reg[NW-1:0]] <= nb_rd;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            used_reg  <= '0;
            ov_reg    <= 1'b0;
            ob_reg    <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            hinit_reg <= 1'b0;
            hclr_reg  <= '0;
            clr_reg   <= '0;
            qh_reg    <= '0;
            qt_reg    <= '0;
            lend_reg  <= '0;
            depth_reg <= '0;
            count_reg <= '0;
            p_reg     <= '0;
        end
        else
        begin
            if (!hinit_reg)
            begin
                hclr_reg <= hclr_reg + (NW+1)'(1);
                if (hclr_reg == (NW+1)'(MAX_NODES - 1))
                    hinit_reg <= 1'b1;
            end
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        a_reg   <= in_beat.node_a;
                        b_reg   <= in_beat.node_b;
                        if (in_beat.cmd == hlbrc_pkg::CMD_QUERY)
                        begin
                            clr_reg   <= '0;
                            state_reg <= ST_CLR;
                        end
                        else if (full_w)
                        begin
                            ob_reg    <= '{hlbrc_pkg::STATUS_FULL, 11'd0};
                            ov_reg    <= 1'b1;
                        end
                        else
                            state_reg <= ST_ADD1;
                    end
                end
                ST_ADD1:
                begin
                    used_reg  <= used_reg + PW'(1);
                    state_reg <= ST_ADD2;
                end
                ST_ADD2:
                begin
                    used_reg  <= used_reg + PW'(1);
                    ob_reg    <= '{hlbrc_pkg::STATUS_DONE, 11'd0};
                    state_reg <= ST_OUT;
                end
                ST_CLR:
                begin
                    clr_reg <= clr_reg + (NW+1)'(1);
                    if (clr_reg == (NW+1)'(MAX_NODES - 1))
                    begin
                        qh_reg    <= '0;
                        qt_reg    <= QW'(1);
                        lend_reg  <= QW'(1);
                        depth_reg <= '0;
                        count_reg <= 11'd1;
                        state_reg <= ST_DEQ;
                    end
                end
                ST_DEQ:
                begin
                    // next node, next level or finish
                    if (qh_reg >= lend_reg)
                    begin
                        if (qh_reg >= qt_reg || depth_reg + 4'd1 >= hop_limit)
                        begin
                            ob_reg    <= '{hlbrc_pkg::STATUS_DONE, count_reg};
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            depth_reg <= depth_reg + 4'd1;
                            lend_reg  <= qt_reg;
                        end
                    end
                    else if (depth_reg >= hop_limit)
                    begin
                        ob_reg    <= '{hlbrc_pkg::STATUS_DONE, count_reg};
                        state_reg <= ST_OUT;
                    end
                    else
                        state_reg <= ST_QRD;
                end
                ST_QRD:
                begin
                    qh_reg    <= qh_reg + QW'(1);
                    state_reg <= ST_HRD;
                end
                ST_HRD:
                    state_reg <= ST_HEAD;
                ST_HEAD:
                begin
                    p_reg <= head_rd;
                    state_reg <= (head_rd == '0) ? ST_DEQ : ST_SLOT;
                end
                ST_SLOT:
                    state_reg <= ST_NB;
                ST_NB:
                    // neighbour valid now; its seen bit is read this cycle
                    state_reg <= ST_SEEN;
                ST_SEEN:
                begin
                    if (!seen_rd && qt_reg < QW'(MAX_NODES))
                    begin
                        qt_reg    <= qt_reg + QW'(1);
                        count_reg <= count_reg + 11'd1;
                    end
                    p_reg     <= next_rd;
                    state_reg <= (next_rd == '0) ? ST_DEQ : ST_SLOT;
                end
                ST_OUT:
                begin
                    if (!ov_reg)
                    begin
                        ov_reg    <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/hop_limited_bfs_reach_counter.sv
// ----------------------------------------------------------------------------
// hop_limited_bfs_reach_counter
// Depth-limited breadth-first reach counter over stored adjacency lists.
// ----------------------------------------------------------------------------
// Input channel: one beat per command (add edge, or query from a source node).
// Output channel: one beat per command with status and reached_count.
// An edge add presents its output beat after the ADD1, ADD2 and OUT states, or
// in the cycle after acceptance when the store is full. A query first clears
// the seen map, then passes DEQ, QRD, HRD and HEAD per dequeued node, SLOT, NB
// and SEEN per adjacency slot walked, and DEQ once more per hop level.
// One command is in flight at a time.
// While the list-head memory is cleared after reset, no input beat is taken;
// configuration writes are accepted throughout.
// hop_limit is written over the APB port at address 0 and reads back there.
// A stalled output beat is held in its register; the next command is taken
// once that beat leaves.
// ----------------------------------------------------------------------------
module hop_limited_bfs_reach_counter #(
    parameter int MAX_SLOTS = 8192
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [hlbrc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    hlbrc_if.sink       in_ch,
    hlbrc_if.source     out_ch
);
    logic [hlbrc_pkg::HOP_LIMIT_W-1:0] hop_limit_reg;

    assign pready = 1'b1;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hop_limit_reg <= hlbrc_pkg::HOP_LIMIT_RESET;
        else if (psel && penable && pwrite && paddr == hlbrc_pkg::REG_HOP_LIMIT)
            hop_limit_reg <= pwdata[hlbrc_pkg::HOP_LIMIT_W-1:0];
    end

    assign prdata = (paddr == hlbrc_pkg::REG_HOP_LIMIT) ? {28'd0, hop_limit_reg} : 32'd0;

    hlbrc_ctrl #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hop_limit (hop_limit_reg),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_beat   (in_ch.payload),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_beat  (out_ch.payload)
    );
endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hop-limited reach counter: edge adds and
// reach queries are driven on the input channel, hop_limit is set over APB
// between phases, and every output beat is checked against a local model
// of the adjacency store and the depth-limited breadth-first walk.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_NODES   = 1024;
    localparam int N_SLOTS   = 8192;
    localparam int CYCLE_CAP = 2000000;

    // Adjacency store mirror, reach prediction and result checking
    class reach_scoreboard;
        int unsigned hop;
        int unsigned heads [N_NODES];
        int unsigned links [N_SLOTS];
        int unsigned nbrs  [N_SLOTS];
        int unsigned used;
        hlbrc_pkg::out_beat_t awaited [$];
        int          fails;

        function new();
            hop  = 32'(hlbrc_pkg::HOP_LIMIT_RESET);
            used = 0;
            fails = 0;
            foreach (heads[i]) heads[i] = 0;
        endfunction

        function void link(int unsigned from, int unsigned to);
            nbrs[used]  = to;
            links[used] = heads[from];
            heads[from] = used + 1;
            used++;
        endfunction

        function int unsigned reach(int unsigned src);
            bit          seen [N_NODES];
            int unsigned walk [N_NODES];
            int unsigned qh, qt, lvl_end, depth, cnt, p, d, nb;
            qh = 0; qt = 0; depth = 0; cnt = 1;
            foreach (seen[i]) seen[i] = 0;
            walk[qt++] = src;
            seen[src] = 1;
            lvl_end = qt;
            while (qh < qt && depth < hop)
            begin
                while (qh < lvl_end)
                begin
                    d = walk[qh++];
                    p = heads[d];
                    while (p != 0)
                    begin
                        nb = nbrs[p - 1];
                        if (!seen[nb] && qt < N_NODES)
                        begin
                            seen[nb] = 1;
                            walk[qt++] = nb;
                            cnt++;
                        end
                        p = links[p - 1];
                    end
                end
                depth++;
                lvl_end = qt;
            end
            return cnt;
        endfunction

        // Predict the beat caused by one accepted command
        function void note_command(hlbrc_pkg::in_beat_t cmd);
            hlbrc_pkg::out_beat_t e;
            e = '0;
            if (cmd.cmd == hlbrc_pkg::CMD_ADD_EDGE)
            begin
                if (used > N_SLOTS - 2)
                    e.status = hlbrc_pkg::STATUS_FULL;
                else
                begin
                    link(cmd.node_a, cmd.node_b);
                    link(cmd.node_b, cmd.node_a);
                    e.status = hlbrc_pkg::STATUS_DONE;
                end
            end
            else
            begin
                e.status = hlbrc_pkg::STATUS_DONE;
                e.reached_count = 11'(reach(cmd.node_a));
            end
            awaited = {awaited, e};
        endfunction

        function void check_result(hlbrc_pkg::out_beat_t got);
            hlbrc_pkg::out_beat_t e;
            if (awaited.size() == 0)
            begin
                fails++;
                if (fails <= 10) $display("unexpected result beat %p", got);
                return;
            end
            e = awaited.pop_front();
            if (got.status !== e.status || got.reached_count !== e.reached_count)
            begin
                fails++;
                if (fails <= 10)
                    $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                             e.status, got.status, e.reached_count, got.reached_count);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [hlbrc_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          cycles = 0;
    int          results_seen = 0;
    bit          quiet = 0;

    hlbrc_if #(.PAYLOAD_T(hlbrc_pkg::in_beat_t))  in_ch ();
    hlbrc_if #(.PAYLOAD_T(hlbrc_pkg::out_beat_t)) out_ch ();

    reach_scoreboard sb = new();

    hop_limited_bfs_reach_counter dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid   = 0;
        in_ch.payload = '0;
        out_ch.ready  = 0;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check each output beat
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            sb.check_result(out_ch.payload);
            results_seen <= results_seen + 1;
        end
    end

    // Drive ready with random stalls and one long hold-off
    initial
    begin : sink_proc
        bit held;
        held = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen == 30)
            begin
                held = 1;
                out_ch.ready <= 0;
                repeat (300) @(posedge clk);
            end
            out_ch.ready <= quiet || ($urandom_range(0, 99) >= 7);
        end
    end

    // Write hop_limit, then read it back mid-cycle
    task automatic write_hop(logic [3:0] value);
        @(posedge clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= hlbrc_pkg::REG_HOP_LIMIT; pwdata <= {28'b0, value};
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(negedge clk);
        if (!pready || prdata !== {28'b0, value})
        begin
            sb.fails++;
            if (sb.fails <= 10)
                $display("hop_limit readback: exp %0d got %0d", value, prdata);
        end
        sb.hop = 32'(value);
        @(posedge clk);
    endtask

    task automatic send(logic c, logic [9:0] a, logic [9:0] b);
        hlbrc_pkg::in_beat_t beat;
        bit                  taken;
        beat.cmd = c; beat.node_a = a; beat.node_b = b;
        taken = 0;
        while (!quiet && $urandom_range(0, 99) < 7)
        begin
            in_ch.valid <= 0;
            @(posedge clk);
        end
        in_ch.valid   <= 1;
        in_ch.payload <= beat;
        // ready depends on registers only, so its mid-cycle value holds at the edge
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ch.ready;
            @(posedge clk);
        end
        sb.note_command(beat);
    endtask

    // Lower valid and wait for the block to drain
    task automatic settle();
        in_ch.valid <= 0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [9:0] pick_node();
        if ($urandom_range(0, 9) == 0) return 10'($urandom_range(0, N_NODES - 1));
        return 10'($urandom_range(0, 39));
    endfunction

    initial
    begin : stim
        logic [3:0] hops [4];
        hops = '{4'd15, 4'd1, 4'd3, 4'd0};
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // Directed: chain, self loop, duplicate, top node, isolated source
        for (int i = 0; i < 8; i++) send(hlbrc_pkg::CMD_ADD_EDGE, 10'(i), 10'(i + 1));
        send(hlbrc_pkg::CMD_ADD_EDGE, 10'd5, 10'd5);
        send(hlbrc_pkg::CMD_ADD_EDGE, 10'd0, 10'd1);
        send(hlbrc_pkg::CMD_ADD_EDGE, 10'd1023, 10'd0);
        send(hlbrc_pkg::CMD_ADD_EDGE, 10'd1023, 10'd682);
        send(hlbrc_pkg::CMD_QUERY, 10'd0, 10'd1023);
        send(hlbrc_pkg::CMD_QUERY, 10'd1023, 10'd0);
        send(hlbrc_pkg::CMD_QUERY, 10'd500, 10'd0);
        send(hlbrc_pkg::CMD_QUERY, 10'd5, 10'd341);
        settle();
        write_hop(4'd0);
        send(hlbrc_pkg::CMD_QUERY, 10'd0, 10'd0);
        send(hlbrc_pkg::CMD_QUERY, 10'd1023, 10'd0);
        settle();
        write_hop(4'd15);
        send(hlbrc_pkg::CMD_QUERY, 10'd8, 10'd0);
        send(hlbrc_pkg::CMD_QUERY, 10'd682, 10'd0);
        settle();

        // Random phases over small graphs
        for (int ph = 0; ph < 4; ph++)
        begin
            write_hop(ph == 3 ? 4'($urandom_range(1, 14)) : hops[ph]);
            for (int k = 0; k < 30; k++)
            begin
                quiet = (ph == 2);
                if (ph == 1 && k == 17)
                begin
                    in_ch.valid <= 0;
                    while (sb.awaited.size() != 0) @(posedge clk);
                end
                if ($urandom_range(0, 99) < 65)
                    send(hlbrc_pkg::CMD_ADD_EDGE, pick_node(), pick_node());
                else
                    send(hlbrc_pkg::CMD_QUERY, pick_node(), 10'($urandom));
            end
            quiet = 0;
            settle();
        end

        // Short hop limit over the accumulated graph
        write_hop(4'd2);
        send(hlbrc_pkg::CMD_QUERY, pick_node(), 10'd0);
        send(hlbrc_pkg::CMD_ADD_EDGE, 10'd3, 10'd4);
        settle();
        repeat (50) @(posedge clk);

        if (sb.fails == 0 && sb.awaited.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
